// ----- sv/pkrt_pkg.sv -----
// Shared constants, types and codes of the per-point range tracker.
package pkrt_pkg;

    localparam int unsigned POINTS      = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned VAL_W       = 64;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned ADDR_W      = $clog2(POINTS);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bound_moved codes
    localparam logic [1:0] MOVE_NONE = 2'd0;
    localparam logic [1:0] MOVE_MIN  = 2'd1;
    localparam logic [1:0] MOVE_MAX  = 2'd2;

    // one stored entry; an all-zero word is an empty entry
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] min_v;
        logic [VAL_W-1:0] max_v;
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] moves;
        logic [VAL_W-1:0] total;
    } entry_t;

    // classified item as it waits between front and back
    typedef struct packed {
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  value;
        logic              sgn;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } front_stat_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

    typedef struct packed {
        logic             created;
        logic [1:0]       bound_moved;
        logic [VAL_W-1:0] min_value;
        logic [VAL_W-1:0] max_value;
        logic [CNT_W-1:0] exec_count;
        logic [CNT_W-1:0] update_count;
        logic [VAL_W-1:0] change_total;
    } res_t;

endpackage

// ----- sv/pkrt_obs_if.sv -----
// Observation channel: valid/ready handshake with the input item fields.
interface pkrt_obs_if import pkrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] point_index;
    logic [VAL_W-1:0] sample_value;
    logic             is_signed;

    modport source (output valid, output point_index, output sample_value,
                    output is_signed, input ready);
    modport sink   (input valid, input point_index, input sample_value,
                    input is_signed, output ready);
endinterface

// ----- sv/pkrt_res_if.sv -----
// Result channel: valid/ready handshake with the updated entry fields.
interface pkrt_res_if import pkrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             created;
    logic [1:0]       bound_moved;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
    logic [CNT_W-1:0] exec_count;
    logic [CNT_W-1:0] update_count;
    logic [VAL_W-1:0] change_total;

    modport source (output valid, output created, output bound_moved,
                    output min_value, output max_value, output exec_count,
                    output update_count, output change_total, input ready);
    modport sink   (input valid, input created, input bound_moved,
                    input min_value, input max_value, input exec_count,
                    input update_count, input change_total, output ready);
endinterface

// ----- sv/pkrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pkrt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- sv/pkrt_front.sv -----
// Front end: accept observations, check the index range and queue them.
module pkrt_front import pkrt_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    pkrt_obs_if.sink      obs,
    input  back_stat_t    bstat,
    output front_stat_t   fstat
);

    q_item_t           q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              full;
    q_item_t           new_item;

    function automatic logic [QPTR_W-1:0] adv_ptr(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign obs.ready = !full && !bstat.clearing;
    assign push      = obs.valid && obs.ready;

    always_comb
    begin
        new_item.in_range = (32'(obs.point_index) < POINTS);
        new_item.addr     = ADDR_W'(obs.point_index);
        new_item.value    = obs.sample_value;
        new_item.sgn      = obs.is_signed;
    end

    always_comb
    begin
        wr_ptr_next = push ? adv_ptr(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = bstat.pop ? adv_ptr(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !bstat.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && bstat.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign fstat.valid = (cnt_reg != '0);
    assign fstat.item  = q_reg[rd_ptr_reg];

endmodule

// ----- sv/pkrt_back.sv -----
// Back end: clear the entry store, then read, compare and write back each item.
module pkrt_back import pkrt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  front_stat_t       fstat,
    output back_stat_t        bstat,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output entry_t            ram_wdata,
    output logic [ADDR_W-1:0] ram_raddr,
    input  entry_t            ram_rdata,
    pkrt_res_if.source        res
);

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_CALC  = 4'b0100,
        B_WRITE = 4'b1000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    q_item_t           cur_reg, cur_next;
    entry_t            ent_reg, ent_next;
    logic              lt_min_reg, lt_min_next;
    logic              gt_max_reg, gt_max_next;
    logic [VAL_W-1:0]  dist_reg, dist_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;
    entry_t            upd_ent;
    res_t              upd_res;
    logic              out_free;

    function automatic logic less64(input logic [VAL_W-1:0] a,
                                    input logic [VAL_W-1:0] b,
                                    input logic             sgn);
        logic [VAL_W-1:0] fa;
        logic [VAL_W-1:0] fb;
        fa = a ^ {sgn, {(VAL_W-1){1'b0}}};
        fb = b ^ {sgn, {(VAL_W-1){1'b0}}};
        return fa < fb;
    endfunction

    assign out_free = !out_valid_reg || res.ready;

    // updated entry and result from the registered compare
    always_comb
    begin
        upd_ent             = ent_reg;
        upd_res             = '0;
        upd_res.bound_moved = MOVE_NONE;
        if (!ent_reg.valid)
        begin
            upd_ent.valid   = 1'b1;
            upd_ent.min_v   = cur_reg.value;
            upd_ent.max_v   = cur_reg.value;
            upd_ent.seen    = CNT_W'(1);
            upd_ent.moves   = '0;
            upd_ent.total   = '0;
            upd_res.created = 1'b1;
        end
        else
        begin
            upd_ent.seen = ent_reg.seen + 1'b1;
            if (lt_min_reg)
            begin
                upd_ent.total       = ent_reg.total + dist_reg;
                upd_ent.moves       = ent_reg.moves + 1'b1;
                upd_ent.min_v       = cur_reg.value;
                upd_res.bound_moved = MOVE_MIN;
            end
            else if (gt_max_reg)
            begin
                upd_ent.total       = ent_reg.total + dist_reg;
                upd_ent.moves       = ent_reg.moves + 1'b1;
                upd_ent.max_v       = cur_reg.value;
                upd_res.bound_moved = MOVE_MAX;
            end
        end
        upd_res.min_value    = upd_ent.min_v;
        upd_res.max_value    = upd_ent.max_v;
        upd_res.exec_count   = upd_ent.seen;
        upd_res.update_count = upd_ent.moves;
        upd_res.change_total = upd_ent.total;
        // an index beyond the store reports all zero
        if (!cur_reg.in_range)
        begin
            upd_res = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        ent_next       = ent_reg;
        lt_min_next    = lt_min_reg;
        gt_max_next    = gt_max_reg;
        dist_next      = dist_reg;
        out_valid_next = out_valid_reg && !res.ready;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.addr;
        ram_wdata      = upd_ent;
        ram_raddr      = fstat.item.addr;
        bstat.pop      = 1'b0;
        bstat.clearing = (state_reg == B_CLEAR);
        case (state_reg)
            B_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(POINTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (fstat.valid)
                begin
                    bstat.pop  = 1'b1;
                    cur_next   = fstat.item;
                    state_next = B_CALC;
                end
            end
            B_CALC:
            begin
                ent_next    = ram_rdata;
                lt_min_next = less64(cur_reg.value, ram_rdata.min_v, cur_reg.sgn);
                gt_max_next = less64(ram_rdata.max_v, cur_reg.value, cur_reg.sgn);
                if (less64(cur_reg.value, ram_rdata.min_v, cur_reg.sgn))
                begin
                    dist_next = ram_rdata.min_v - cur_reg.value;
                end
                else
                begin
                    dist_next = cur_reg.value - ram_rdata.max_v;
                end
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ram_we         = cur_reg.in_range;
                    out_valid_next = 1'b1;
                    res_next       = upd_res;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        ent_reg    <= ent_next;
        lt_min_reg <= lt_min_next;
        gt_max_reg <= gt_max_next;
        dist_reg   <= dist_next;
        res_reg    <= res_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.created      = res_reg.created;
    assign res.bound_moved  = res_reg.bound_moved;
    assign res.min_value    = res_reg.min_value;
    assign res.max_value    = res_reg.max_value;
    assign res.exec_count   = res_reg.exec_count;
    assign res.update_count = res_reg.update_count;
    assign res.change_total = res_reg.change_total;

endmodule

// ----- sv/per_key_range_tracker_top.sv -----
// Path: an accepted item waits in the queue, then passes the back end's idle, compare and
// write-back states, and its result is registered at the output. Items go one at a time
// through that sequence on the single entry memory; a 2-item queue lets the input run ahead.
// Reset: asynchronous, active low; afterwards a clearing pass writes zero to all POINTS (1024)
// entries of the entry memory, and obs.ready stays low until it ends.
module per_key_range_tracker_top import pkrt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pkrt_obs_if.sink   obs,
    pkrt_res_if.source res
);

    front_stat_t       fstat;
    back_stat_t        bstat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    pkrt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .obs   (obs),
        .bstat (bstat),
        .fstat (fstat)
    );

    pkrt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pkrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fstat     (fstat),
        .bstat     (bstat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> !obs.ready)
        else $error("item accepted during clearing pass");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.pop |-> fstat.valid)
        else $error("back end popped an empty queue");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> !res.valid)
        else $error("result presented during clearing pass");

    a_no_ram_write_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.pop |-> !ram_we)
        else $error("entry write collides with a new read");
`endif

endmodule
